>>> design/bresenham_line_stepper_core_defines.svh
// Assertion macros used by the checker of the line stepper.
`ifndef BRESENHAM_LINE_STEPPER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line stepper check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line stepper check failed");

`endif

>>> design/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int STR_BITS   = COORD_BITS + 3;
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int CFG_BITS   = 13;
	localparam int ADDR_BITS  = 24;
	localparam int COLOR_BITS = 32;
	localparam int IDX_BITS   = 1;

	// Unsigned compare width for clipping a non-negative coordinate.
	localparam int CMP_BITS  = (COORD_BITS - 1 > CFG_BITS) ? COORD_BITS - 1 : CFG_BITS;
	localparam int PROD_BITS = COORD_BITS - 1 + CFG_BITS;
	localparam int SUM_BITS  = ((PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS) + 1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = IDX_BITS'(1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]        color;
		logic                         last;
	} pix_t;

endpackage

>>> design/bresenham_line_stepper_core.sv
`timescale 1ns / 1ps

// Bresenham line stepper. An opcode OP_START transaction sets up a line from
// two signed endpoints and a color and returns its first pixel; each OP_STEP
// transaction returns the next pixel along the major axis, with last_pixel on
// the final one, and a step with no line in progress returns nothing. Every
// pixel carries on_screen against screen_width/screen_height and its
// framebuffer offset x + y*screen_width (zero when off screen). While
// in_ready is high one transaction is accepted per cycle: the stepping
// registers update at the input handshake, and the clip compare and the
// row-stride multiply sit in the output stage after the pixel stage register.
// in_ready drops only while both the pixel stage and the output register
// hold results that out_ready has not taken. Write screen_width/screen_height
// through cfg_write only while no line result is outstanding.
module bresenham_line_stepper_core
	import bls_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [IDX_BITS-1:0]          cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0]        color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         pixel_present,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         on_screen,
	output logic [ADDR_BITS-1:0]         pixel_address,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         last_pixel
);

	logic [CFG_BITS-1:0] screen_width_q;
	logic [CFG_BITS-1:0] screen_height_q;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic signed [ERR_BITS-1:0]   error_term_q, diag_increment_q;
	logic [STR_BITS-1:0]          straight_increment_q;
	logic [DIFF_BITS-1:0]         pixels_left_q;
	logic                         steep_q, minor_down_q, active_q;
	logic [COLOR_BITS-1:0]        line_color_q;

	logic signed [COORD_BITS-1:0] cur_x_d, cur_y_d;
	logic signed [ERR_BITS-1:0]   error_term_d, diag_increment_d;
	logic [STR_BITS-1:0]          straight_increment_d;
	logic [DIFF_BITS-1:0]         pixels_left_d;
	logic                         steep_d, minor_down_d, active_d;
	logic [COLOR_BITS-1:0]        line_color_d;
	logic                         emit;
	logic                         last_d;

	logic                         take;
	logic                         out_en;
	logic                         valid_s1;
	pix_t                         pix_s1;

	// Setup arithmetic for a new line
	logic signed [DIFF_BITS-1:0] dx, dy, md;
	logic [DIFF_BITS-1:0]        adx, ady, major, minor;
	logic                        steep_c, swap;

	// Output stage clipping
	logic [CMP_BITS-1:0]  x_cmp, y_cmp, w_cmp, h_cmp;
	logic                 on_c;
	logic [PROD_BITS-1:0] row_off;
	logic [SUM_BITS-1:0]  addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data;
			end else if (cfg_index == REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data;
			end
		end
	end

	assign out_en   = !out_valid || out_ready;
	assign in_ready = !valid_s1 || out_en;
	assign take     = in_valid && in_ready;

	assign dx      = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
	assign dy      = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
	assign adx     = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
	assign ady     = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
	assign steep_c = adx < ady;
	assign swap    = steep_c ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1];
	assign md      = steep_c ? dx : dy;
	assign major   = steep_c ? ady : adx;
	assign minor   = steep_c ? adx : ady;

	always_comb begin
		cur_x_d              = cur_x_q;
		cur_y_d              = cur_y_q;
		error_term_d         = error_term_q;
		diag_increment_d     = diag_increment_q;
		straight_increment_d = straight_increment_q;
		pixels_left_d        = pixels_left_q;
		steep_d              = steep_q;
		minor_down_d         = minor_down_q;
		line_color_d         = line_color_q;
		active_d             = active_q;
		emit                 = 1'b0;
		last_d               = 1'b0;
		if (opcode == OP_START) begin
			emit                 = 1'b1;
			steep_d              = steep_c;
			// Minor span after ordering is -md when swapped
			minor_down_d         = (md == '0) || (md[DIFF_BITS-1] ^ swap);
			error_term_d         = (ERR_BITS'(minor) << 1) - ERR_BITS'(major);
			diag_increment_d     = (ERR_BITS'(minor) - ERR_BITS'(major)) << 1;
			straight_increment_d = STR_BITS'(minor) << 1;
			pixels_left_d        = major;
			cur_x_d              = swap ? end_x : start_x;
			cur_y_d              = swap ? end_y : start_y;
			line_color_d         = color;
			active_d             = major != '0;
			last_d               = major == '0;
		end else if (active_q) begin
			emit = 1'b1;
			if (!error_term_q[ERR_BITS-1]) begin
				if (steep_q) begin
					cur_x_d = minor_down_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				end else begin
					cur_y_d = minor_down_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				end
				error_term_d = error_term_q + diag_increment_q;
			end else begin
				error_term_d = error_term_q + ERR_BITS'(straight_increment_q);
			end
			if (steep_q) begin
				cur_y_d = cur_y_q + 1'b1;
			end else begin
				cur_x_d = cur_x_q + 1'b1;
			end
			pixels_left_d = pixels_left_q - 1'b1;
			active_d      = pixels_left_q != DIFF_BITS'(1);
			last_d        = pixels_left_q == DIFF_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q              <= '0;
			cur_y_q              <= '0;
			error_term_q         <= '0;
			diag_increment_q     <= '0;
			straight_increment_q <= '0;
			pixels_left_q        <= '0;
			steep_q              <= 1'b0;
			minor_down_q         <= 1'b0;
			line_color_q         <= '0;
			active_q             <= 1'b0;
		end else if (take && emit) begin
			cur_x_q              <= cur_x_d;
			cur_y_q              <= cur_y_d;
			error_term_q         <= error_term_d;
			diag_increment_q     <= diag_increment_d;
			straight_increment_q <= straight_increment_d;
			pixels_left_q        <= pixels_left_d;
			steep_q              <= steep_d;
			minor_down_q         <= minor_down_d;
			line_color_q         <= line_color_d;
			active_q             <= active_d;
		end
	end

	// Pixel stage: advances whenever it is empty or the output register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			pix_s1.x     <= cur_x_d;
			pix_s1.y     <= cur_y_d;
			pix_s1.color <= line_color_d;
			pix_s1.last  <= last_d;
		end
	end

	assign x_cmp    = CMP_BITS'(pix_s1.x[COORD_BITS-2:0]);
	assign y_cmp    = CMP_BITS'(pix_s1.y[COORD_BITS-2:0]);
	assign w_cmp    = CMP_BITS'(screen_width_q);
	assign h_cmp    = CMP_BITS'(screen_height_q);
	assign on_c     = !pix_s1.x[COORD_BITS-1] && !pix_s1.y[COORD_BITS-1] &&
	                  (x_cmp < w_cmp) && (y_cmp < h_cmp);
	assign row_off  = PROD_BITS'(pix_s1.y[COORD_BITS-2:0]) * PROD_BITS'(screen_width_q);
	assign addr_sum = SUM_BITS'(row_off) + SUM_BITS'(pix_s1.x[COORD_BITS-2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s1) begin
			pixel_x       <= pix_s1.x;
			pixel_y       <= pix_s1.y;
			on_screen     <= on_c;
			pixel_address <= on_c ? addr_sum[ADDR_BITS-1:0] : '0;
			pixel_color   <= pix_s1.color;
			last_pixel    <= pix_s1.last;
		end
	end

	assign pixel_present = 1'b1;

endmodule

>>> design/bls_checker.sv
`timescale 1ns / 1ps
`include "bresenham_line_stepper_core_defines.svh"

module bls_checker
	import bls_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         pixel_present,
	input logic signed [COORD_BITS-1:0] pixel_x,
	input logic signed [COORD_BITS-1:0] pixel_y,
	input logic                         on_screen,
	input logic [ADDR_BITS-1:0]         pixel_address,
	input logic                         last_pixel
);

	// A stalled result holds its position and last flag
	`BLS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))

	`BLS_ASSERT_NOW(a_off_addr_zero, clk, arst_n, out_valid && !on_screen, pixel_address == '0)

	`BLS_ASSERT_NOW(a_on_nonneg, clk, arst_n, out_valid && on_screen, !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])

	`BLS_ASSERT_NOW(a_present, clk, arst_n, out_valid, pixel_present)

endmodule

bind bresenham_line_stepper_core bls_checker u_bls_checker (.*);

>>> test/bresenham_line_stepper_core_tb.sv
`timescale 1ns / 1ps

module bresenham_line_stepper_core_tb;
	import bls_pkg::*;

	typedef struct packed {
		logic                         present;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         on;
		logic [ADDR_BITS-1:0]         addr;
		logic [COLOR_BITS-1:0]        color;
		logic                         last;
	} line_pixel_t;

	localparam int RANDOM_PIXELS = 1800;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_write;
	logic [IDX_BITS-1:0]          cfg_index;
	logic [CFG_BITS-1:0]          cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic                         opcode;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [COLOR_BITS-1:0]        color;
	logic                         out_valid;
	logic                         out_ready;
	logic                         pixel_present;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         on_screen;
	logic [ADDR_BITS-1:0]         pixel_address;
	logic [COLOR_BITS-1:0]        pixel_color;
	logic                         last_pixel;

	// Line state tracked alongside the block.
	logic signed [COORD_BITS-1:0] pos_x = '0;
	logic signed [COORD_BITS-1:0] pos_y = '0;
	logic signed [ERR_BITS-1:0]   err_acc = '0;
	logic signed [ERR_BITS-1:0]   diag_inc = '0;
	logic [STR_BITS-1:0]          straight_inc = '0;
	logic [DIFF_BITS-1:0]         remaining = '0;
	logic                         steep_line = 1'b0;
	logic                         minor_dec = 1'b0;
	logic [COLOR_BITS-1:0]        line_col = '0;
	logic                         line_busy = 1'b0;
	logic [CFG_BITS-1:0]          scr_w = WIDTH_RESET;
	logic [CFG_BITS-1:0]          scr_h = HEIGHT_RESET;

	line_pixel_t pending_pixels[$];
	int          errors = 0;
	int          results_sent = 0;
	bit          no_gaps = 1'b0;

	bresenham_line_stepper_core dut (.*);

	always #2 clk = ~clk;

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int draw_wait();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic line_pixel_t current_pixel(input logic is_last);
		line_pixel_t r;
		longint      addr_full;
		r.present = 1'b1;
		r.x = pos_x;
		r.y = pos_y;
		r.on = (pos_x >= 0) && (int'(pos_x) < int'(scr_w)) &&
			(pos_y >= 0) && (int'(pos_y) < int'(scr_h));
		addr_full = longint'(pos_x) + longint'(pos_y) * longint'(scr_w);
		r.addr = r.on ? addr_full[ADDR_BITS-1:0] : '0;
		r.color = line_col;
		r.last = is_last;
		return r;
	endfunction

	function automatic line_pixel_t line_start_pixel(
		input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
		input logic [COLOR_BITS-1:0] col);
		int x1, y1, x2, y2, swap_tmp, major, span, minor;
		x1 = sx;
		y1 = sy;
		x2 = ex;
		y2 = ey;
		steep_line = abs_int(x2 - x1) < abs_int(y2 - y1);
		// order endpoints so the major coordinate increases
		if (steep_line ? (y1 > y2) : (x1 > x2)) begin
			swap_tmp = x1; x1 = x2; x2 = swap_tmp;
			swap_tmp = y1; y1 = y2; y2 = swap_tmp;
		end
		if (steep_line) begin
			major = y2 - y1;
			span = x2 - x1;
		end else begin
			major = x2 - x1;
			span = y2 - y1;
		end
		minor_dec = !(span > 0);
		minor = abs_int(span);
		err_acc = ERR_BITS'(2 * minor - major);
		diag_inc = ERR_BITS'(2 * (minor - major));
		straight_inc = STR_BITS'(2 * minor);
		remaining = DIFF_BITS'(major);
		pos_x = COORD_BITS'(x1);
		pos_y = COORD_BITS'(y1);
		line_col = col;
		line_busy = (major != 0);
		return current_pixel(!line_busy);
	endfunction

	function automatic bit line_next_pixel(output line_pixel_t r);
		r = '0;
		if (!line_busy)
			return 1'b0;
		if (!err_acc[ERR_BITS-1]) begin
			if (steep_line)
				pos_x = minor_dec ? COORD_BITS'(pos_x - 1) : COORD_BITS'(pos_x + 1);
			else
				pos_y = minor_dec ? COORD_BITS'(pos_y - 1) : COORD_BITS'(pos_y + 1);
			err_acc = err_acc + diag_inc;
		end else begin
			err_acc = err_acc + ERR_BITS'(straight_inc);
		end
		if (steep_line)
			pos_y = COORD_BITS'(pos_y + 1);
		else
			pos_x = COORD_BITS'(pos_x + 1);
		remaining = remaining - 1'b1;
		line_busy = (remaining != 0);
		r = current_pixel(!line_busy);
		return 1'b1;
	endfunction

	task automatic send_item(input logic op,
		input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
		input logic [COLOR_BITS-1:0] col);
		int          gap;
		line_pixel_t px;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		color <= col;
		do @(posedge clk); while (!in_ready);
		if (op == OP_START) begin
			pending_pixels.push_back(line_start_pixel(sx, sy, ex, ey, col));
			results_sent++;
		end else if (line_next_pixel(px)) begin
			pending_pixels.push_back(px);
			results_sent++;
		end
	endtask

	task automatic send_step();
		send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
	endtask

	// Start a line, walk it to the end, then send the extra steps past the end.
	task automatic draw_line(input int x1, y1, x2, y2,
		input logic [COLOR_BITS-1:0] col, input int extra);
		send_item(OP_START, COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2),
			COORD_BITS'(y2), col);
		while (line_busy)
			send_step();
		repeat (extra) send_step();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_screen(input int w, h);
		cfg_write <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= CFG_BITS'(w);
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= CFG_BITS'(h);
		@(posedge clk);
		cfg_write <= 1'b0;
		scr_w = CFG_BITS'(w);
		scr_h = CFG_BITS'(h);
	endtask

	task automatic test_reset_screen();
		// nothing in progress after reset
		send_step();
		// single-pixel line on the far corner of the default screen
		draw_line(639, 479, 639, 479, 32'hFFFF_FFFF, 1);
		draw_line(640, 480, 640, 480, 32'h0, 0);
	endtask

	task automatic test_line_shapes();
		draw_line(0, 0, 4, -2, 32'h1234_5678, 0);
		draw_line(3, 5, 1, 0, 32'hA5A5_5A5A, 0);
		// no minor span: minor direction flagged down but never used
		draw_line(10, 7, 7, 7, 32'h0000_00FF, 0);
		draw_line(5, 9, 5, 12, 32'hFF00_0000, 0);
		// equal spans take x as the major axis
		draw_line(2, 2, -1, -1, 32'h8000_0001, 0);
		// extreme endpoints; each new start drops the line before it
		send_item(OP_START, COORD_BITS'(-32768), COORD_BITS'(32767),
			COORD_BITS'(32767), COORD_BITS'(-32768), 32'h0);
		send_step();
		send_item(OP_START, COORD_BITS'(32767), COORD_BITS'(32767),
			COORD_BITS'(-32768), COORD_BITS'(-32768), 32'hFFFF_FFFF);
		send_step();
		send_item(OP_START, COORD_BITS'(0), COORD_BITS'(32767),
			COORD_BITS'(-1), COORD_BITS'(-32768), 32'h7FFF_FFFF);
		send_step();
		draw_line(1, 1, 1, 1, 32'h0, 0);
	endtask

	task automatic test_screen_extremes();
		int widths[6]  = '{0, 8191, 1, 4096, 0, 640};
		int heights[6] = '{0, 8191, 1, 4096, 480, 0};
		int w, h;
		for (int i = 0; i < 6; i++) begin
			w = widths[i];
			h = heights[i];
			wait_idle();
			set_screen(w, h);
			draw_line(-1, -1, 2, 1, $urandom, 0);
			draw_line(w - 2, h + 1, w + 1, h - 3, $urandom, 0);
			// far corner: offset runs past 24 bits on the widest screen
			draw_line(8190, 8190, 8186, 8185, $urandom, 0);
		end
	endtask

	task automatic random_line();
		int kind, spread, x0, y0, dx, dy;
		kind = $urandom_range(0, 19);
		if (kind < 14) begin
			spread = ($urandom_range(0, 9) == 0) ? 300 : 24;
			x0 = int'($urandom_range(0, scr_w + 32)) - 16;
			y0 = int'($urandom_range(0, scr_h + 32)) - 16;
			dx = int'($urandom_range(0, 2 * spread)) - spread;
			dy = int'($urandom_range(0, 2 * spread)) - spread;
			if (kind == 0) begin
				// abandon part way; the next start drops it
				send_item(OP_START, COORD_BITS'(x0), COORD_BITS'(y0),
					COORD_BITS'(x0 + dx), COORD_BITS'(y0 + dy), $urandom);
				repeat ($urandom_range(0, 3)) send_step();
			end else begin
				draw_line(x0, y0, x0 + dx, y0 + dy, $urandom,
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			end
		end else if (kind < 17) begin
			send_item(OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
				COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
			repeat ($urandom_range(0, 5)) send_step();
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(1'($urandom_range(0, 1)), COORD_BITS'($urandom),
					COORD_BITS'($urandom), COORD_BITS'($urandom),
					COORD_BITS'($urandom), $urandom);
		end
	endtask

	task automatic test_random_lines();
		int base;
		base = results_sent;
		while (results_sent - base < RANDOM_PIXELS) begin
			if ($urandom_range(0, 1) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
					1: set_screen($urandom_range(0, 8191), $urandom_range(0, 8191));
					2: set_screen($urandom_range(1, 64), $urandom_range(1, 64));
					default: set_screen(640, 480);
				endcase
			end
			no_gaps = ($urandom_range(0, 4) == 0);
			repeat (4) random_line();
		end
		no_gaps = 1'b0;
	endtask

	task automatic finish_run();
		int drain_cycles;
		in_valid <= 1'b0;
		drain_cycles = 0;
		while (pending_pixels.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (pending_pixels.size() != 0) begin
			$display("%0d expected pixels never arrived", pending_pixels.size());
			errors++;
		end
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("bresenham_line_stepper_core_tb OK");
		else
			$display("bresenham_line_stepper_core_tb NOT OK");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_START;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		color = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_screen();
		test_line_shapes();
		test_screen_extremes();
		test_random_lines();
		finish_run();
	end

	// Receiver: stall a random number of cycles before each transaction.
	initial begin : pixel_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_pixels
		line_pixel_t got;
		line_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			got.present = pixel_present;
			got.x = pixel_x;
			got.y = pixel_y;
			got.on = on_screen;
			got.addr = pixel_address;
			got.color = pixel_color;
			got.last = last_pixel;
			if (pending_pixels.size() == 0) begin
				if (errors < 10)
					$display("unexpected pixel x=%0d y=%0d at %0t", got.x, got.y, $realtime);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					if (errors < 10) begin
						$display("pixel mismatch at %0t", $realtime);
						$display("  expected present=%0b x=%0d y=%0d on=%0b addr=%h color=%h last=%0b",
							want.present, want.x, want.y, want.on, want.addr, want.color,
							want.last);
						$display("  actual   present=%0b x=%0d y=%0d on=%0b addr=%h color=%h last=%0b",
							got.present, got.x, got.y, got.on, got.addr, got.color, got.last);
					end
					errors++;
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("bresenham_line_stepper_core_tb NOT OK");
		$finish;
	end

endmodule
